// File: sv/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;

  // Status codes of a result.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO_PER   = 3'd1;
  localparam logic [2:0] ST_NO_SLOT    = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
  localparam logic [2:0] ST_BAD_TIMER  = 3'd4;

  // Register index of the tick resolution.
  localparam logic [1:0] REG_TICK_RES = 2'd0;
  localparam logic [19:0] TICK_RES_RESET = 20'd10000;

  // At most this many results are emitted by one tick request.
  localparam logic [5:0] MAX_RESULTS = 6'd32;

  // Steps of the shared divider for a period conversion and a fire count.
  localparam logic [5:0] CONV_STEPS = 6'd36;
  localparam logic [5:0] FIRE_STEPS = 6'd8;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] elapsed_ticks;
    logic [31:0] period_us;
    logic [15:0] user_tag;
    logic [7:0]  slot_index;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [31:0] period_ticks;
    logic        fired;
    logic [7:0]  fire_count;
    logic [15:0] owner_tag;
    logic        last;
  } out_rsp_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_RESP  = 9'b000001000,
    S_TRD   = 9'b000010000,
    S_TCHK  = 9'b000100000,
    S_TDIV  = 9'b001000000,
    S_TFIRE = 9'b010000000,
    S_TEND  = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

// File: sv/periodic_timer_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// Bank of SLOTS periodic timers behind one request channel and one result
// channel. A start request converts its period with a shared restoring
// divider, one quotient bit per cycle. It walks the slots for the lowest free
// one and then divides. With no free slot, the answer comes after the walk
// over all slots. A close request answers without a walk or a divide. A tick
// request walks all slots through the slot memories: it reads and checks each
// slot in use and skips each free slot. Each slot that fires adds a divide for
// its fire count, unless the count saturates, and one result. The block takes
// a new request only when the previous one is done, and results wait in one
// output register.
module periodic_timer_bank #(
  parameter int SLOTS    = 32,
  parameter int TAG_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire ptb_pkg::in_req_t in_req_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ptb_pkg::out_rsp_t    out_rsp_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [1:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [8:0] SLOTS_9 = 9'(SLOTS);
  localparam logic [1:0] REG_TICK_RES_ADDR = ptb_pkg::REG_TICK_RES;

  // Configuration register.
  logic [19:0] res_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == REG_TICK_RES_ADDR);
  assign prdata = 32'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= ptb_pkg::TICK_RES_RESET;
    end else if (cfg_we) begin
      res_q <= pwdata[19:0];
    end
  end

  // Control and datapath registers.
  ptb_pkg::state_e   state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  ptb_pkg::in_req_t  req_q, req_d;
  ptb_pkg::out_rsp_t rsp_q, rsp_d;
  logic [SLOTS-1:0]  in_use_q, in_use_d;
  logic              pend_v_q, pend_v_d;
  ptb_pkg::out_rsp_t pend_q, pend_d;
  logic [5:0]        res_cnt_q, res_cnt_d;
  logic [7:0]        fcnt_q, fcnt_d;
  logic              out_valid_q, out_valid_d;
  ptb_pkg::out_rsp_t out_q, out_d;

  // Shared divider registers.
  logic [31:0] rem_q, rem_d;
  logic [35:0] dvd_q, dvd_d;
  logic [31:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;

  // Slot memories.
  logic [TAG_BITS-1:0] tag_mem [SLOTS];
  logic [31:0]         per_mem [SLOTS];
  logic [31:0]         el_mem  [SLOTS];
  logic [TAG_BITS-1:0] tag_rd_q;
  logic [31:0]         per_rd_q;
  logic [31:0]         el_rd_q;
  logic                mem_we;
  logic                el_we;
  logic [31:0]         el_wdata;
  logic [31:0]         per_wdata;

  // Combinational helpers.
  logic              out_free;
  logic [33:0]       trial;
  logic              div_step;
  logic [35:0]       prod10;
  logic [19:0]       res_eff;
  logic [32:0]       el_sum;
  logic [31:0]       el_sat;
  logic              close_ok;
  logic [7:0]        idx8;
  logic [31:0]       tag32_wr;
  logic [31:0]       tag32_rd;
  logic [TAG_BITS-1:0] tag_wdata;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ptb_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign idx8      = 8'(idx_q);
  assign tag32_wr  = 32'(req_q.user_tag);
  assign tag_wdata = tag32_wr[TAG_BITS-1:0];
  assign tag32_rd  = 32'(tag_rd_q);
  assign prod10    = ({4'd0, in_req_i.period_us} << 3) + ({4'd0, in_req_i.period_us} << 1);
  assign res_eff   = (res_q == 20'd0) ? 20'd1 : res_q;
  assign el_sum    = {1'b0, el_rd_q} + 33'(req_q.elapsed_ticks);
  assign el_sat    = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  assign close_ok  = ({1'b0, in_req_i.slot_index} < SLOTS_9) &&
                     in_use_q[in_req_i.slot_index[IW-1:0]];

  // One restoring divider step: shift in the next dividend bit, subtract.
  assign div_step = ((state_q == ptb_pkg::S_DIV) || (state_q == ptb_pkg::S_TDIV)) &&
                    (cnt_q != 6'd0);
  assign trial    = {1'b0, rem_q, dvd_q[35]} - {2'b00, dsr_q};

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    in_use_d    = in_use_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    res_cnt_d   = res_cnt_q;
    fcnt_d      = fcnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dsr_d       = dsr_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    el_we       = 1'b0;
    el_wdata    = el_sat;
    per_wdata   = 32'd0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (div_step) begin
      cnt_d = cnt_q - 6'd1;
      dvd_d = {dvd_q[34:0], !trial[33]};
      rem_d = trial[33] ? {rem_q[30:0], dvd_q[35]} : trial[31:0];
    end

    case (state_q)
      ptb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          rsp_d = '0;
          rsp_d.last = 1'b1;
          idx_d = '0;
          case (in_req_i.func)
            ptb_pkg::FUNC_TICK: begin
              pend_v_d  = 1'b0;
              res_cnt_d = 6'd0;
              state_d   = ptb_pkg::S_TRD;
            end
            ptb_pkg::FUNC_START: begin
              if (in_req_i.period_us == 32'd0) begin
                rsp_d.status = ptb_pkg::ST_ZERO_PER;
                state_d      = ptb_pkg::S_RESP;
              end else begin
                rem_d   = 32'd0;
                dvd_d   = prod10;
                dsr_d   = 32'(res_eff);
                cnt_d   = ptb_pkg::CONV_STEPS;
                state_d = ptb_pkg::S_SCAN;
              end
            end
            ptb_pkg::FUNC_CLOSE: begin
              if (close_ok) begin
                in_use_d[in_req_i.slot_index[IW-1:0]] = 1'b0;
                rsp_d.slot = in_req_i.slot_index[4:0];
              end else begin
                rsp_d.status = ptb_pkg::ST_BAD_TIMER;
              end
              state_d = ptb_pkg::S_RESP;
            end
            default: begin
              state_d = ptb_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Look for the lowest free slot, one slot a cycle.
      ptb_pkg::S_SCAN: begin
        if (!in_use_q[idx_q]) begin
          state_d = ptb_pkg::S_DIV;
        end else if (idx_q == LAST_IDX) begin
          rsp_d.status = ptb_pkg::ST_NO_SLOT;
          cnt_d        = 6'd0;
          state_d      = ptb_pkg::S_RESP;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      // Period conversion; the quotient is complete once the count runs out.
      ptb_pkg::S_DIV: begin
        if (cnt_q == 6'd0) begin
          if (dvd_q == 36'd0) begin
            rsp_d.status = ptb_pkg::ST_TOO_SHORT;
          end else begin
            per_wdata         = (dvd_q[35:32] != 4'd0) ? 32'hFFFF_FFFF : dvd_q[31:0];
            mem_we            = 1'b1;
            el_we             = 1'b1;
            el_wdata          = 32'd0;
            in_use_d[idx_q]   = 1'b1;
            rsp_d.slot        = idx8[4:0];
            rsp_d.period_ticks = per_wdata;
          end
          state_d = ptb_pkg::S_RESP;
        end
      end

      ptb_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = rsp_q;
          state_d     = ptb_pkg::S_IDLE;
        end
      end

      // Issue the slot read, or skip a free slot.
      ptb_pkg::S_TRD: begin
        if (in_use_q[idx_q]) begin
          state_d = ptb_pkg::S_TCHK;
        end else if (idx_q == LAST_IDX) begin
          state_d = ptb_pkg::S_TEND;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      // Add the elapsed ticks and check the slot for expiry.
      ptb_pkg::S_TCHK: begin
        el_we = 1'b1;
        if ((per_rd_q == 32'd0) || (el_sat < per_rd_q)) begin
          if (idx_q == LAST_IDX) begin
            state_d = ptb_pkg::S_TEND;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = ptb_pkg::S_TRD;
          end
        end else begin
          el_wdata = 32'd0;
          if (32'(el_sat[31:8]) >= per_rd_q) begin
            fcnt_d  = 8'hFF;
            state_d = ptb_pkg::S_TFIRE;
          end else begin
            rem_d   = 32'(el_sat[31:8]);
            dvd_d   = {el_sat[7:0], 28'd0};
            dsr_d   = per_rd_q;
            cnt_d   = ptb_pkg::FIRE_STEPS;
            state_d = ptb_pkg::S_TDIV;
          end
        end
      end

      ptb_pkg::S_TDIV: begin
        if (cnt_q == 6'd0) begin
          fcnt_d  = dvd_q[7:0];
          state_d = ptb_pkg::S_TFIRE;
        end
      end

      // Hold the newest fire result back so that the final one can carry last.
      ptb_pkg::S_TFIRE: begin
        if ((res_cnt_q >= ptb_pkg::MAX_RESULTS) || !pend_v_q || out_free) begin
          if (res_cnt_q < ptb_pkg::MAX_RESULTS) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_v_d            = 1'b1;
            pend_d              = '0;
            pend_d.status       = ptb_pkg::ST_OK;
            pend_d.slot         = idx8[4:0];
            pend_d.period_ticks = per_rd_q;
            pend_d.fired        = 1'b1;
            pend_d.fire_count   = fcnt_q;
            pend_d.owner_tag    = tag32_rd[15:0];
            res_cnt_d           = res_cnt_q + 6'd1;
          end
          if (idx_q == LAST_IDX) begin
            state_d = ptb_pkg::S_TEND;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = ptb_pkg::S_TRD;
          end
        end
      end

      ptb_pkg::S_TEND: begin
        if (!pend_v_q) begin
          state_d = ptb_pkg::S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          out_d.last  = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = ptb_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ptb_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptb_pkg::S_IDLE;
      in_use_q    <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= 6'd0;
      res_cnt_q   <= 6'd0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      res_cnt_q   <= res_cnt_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    pend_q <= pend_d;
    fcnt_q <= fcnt_d;
    out_q  <= out_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[idx_q] <= tag_wdata;
      per_mem[idx_q] <= per_wdata;
    end
    if (el_we) begin
      el_mem[idx_q] <= el_wdata;
    end
    tag_rd_q <= tag_mem[idx_q];
    per_rd_q <= per_mem[idx_q];
    el_rd_q  <= el_mem[idx_q];
  end

  // A fired result always reports success and a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.fired) |->
      (out_rsp_o.status == ptb_pkg::ST_OK && out_rsp_o.fire_count != 8'd0))
    else $error("fired result with bad status or count");

  // The divider count is nonzero only in its own states and during the slot scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 6'd0) |->
      (state_q == ptb_pkg::S_DIV || state_q == ptb_pkg::S_TDIV ||
       state_q == ptb_pkg::S_SCAN))
    else $error("divider busy outside a divide");

  // A tick never emits more than the result cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= ptb_pkg::MAX_RESULTS)
    else $error("too many tick results");

  // A held fire result exists only while a tick is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q != ptb_pkg::S_IDLE))
    else $error("pending fire result left behind");

endmodule
`default_nettype wire
